/* rtl/core/hptd_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Hysteresis peak/trough detector package
// Action codes, tracker direction codes, event kinds and the widths of the
// reported index and ordinal.
// ---------------------------------------------------------------------------
package hptd_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_MEASURE = 2'd1;
  localparam logic [1:0] ACT_DETECT  = 2'd2;

  // Event kinds.
  localparam logic EVT_PEAK   = 1'b0;
  localparam logic EVT_TROUGH = 1'b1;

  // Widths of the reported index and ordinal.
  localparam int INDEX_W   = 16;
  localparam int ORDINAL_W = 16;

  // Hysteresis tracker direction.
  typedef enum logic [1:0] {
    DIR_UNDECIDED = 2'd0,
    DIR_RISING    = 2'd1,
    DIR_FALLING   = 2'd2
  } dir_e;

endpackage : hptd_pkg
`default_nettype wire

/* rtl/core/hptd_div5.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Divide by five
// Unsigned division by the constant five through multiplication with a
// rounded-up reciprocal. Purely combinational and exact for every dividend.
// ---------------------------------------------------------------------------
module hptd_div5 #(
  parameter int DW = 17
) (
  input  logic [DW-1:0] dividend_i,
  output logic [DW-1:0] quotient_o
);

  // The reciprocal 2^(DW+3) / 5, rounded up, leaves an error below one
  // fifth for any DW-bit dividend, so the floor is exact.
  localparam int Shift  = DW + 3;
  localparam int RecipW = DW + 1;
  localparam int ProdW  = DW + RecipW;
  localparam longint unsigned Recip = ((64'd1 << Shift) + 64'd4) / 64'd5;

  logic [RecipW-1:0] recip;
  logic [ProdW-1:0]  product;

  assign recip   = RecipW'(Recip);
  assign product = {{RecipW{1'b0}}, dividend_i} * {{DW{1'b0}}, recip};

  // The quotient of a DW-bit value by five fits in DW - 2 bits.
  assign quotient_o = {2'b00, product[ProdW-1:Shift]};

endmodule : hptd_div5
`default_nettype wire

/* rtl/core/hysteresis_peak_trough_detector.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Hysteresis peak/trough detector
// Measures the range of a sample record, then tracks the record again with
// a hysteresis of floor(2 * range / 5) and reports confirmed extrema.
//
//   Channel  Handshake               Payload
//   -------  ----------------------  -------------------------------------
//   in       in_valid_i / in_stall_o  action_i, sample_i
//   out      out_valid_o / out_stall_i event_kind_o, event_index_o,
//                                     event_ordinal_o
//
// One transaction per cycle, of any action, is taken unless a result stalls.
// The stage register is processed once the result register is free, and
// an event that it yields is loaded into the result register to be taken.
// The threshold for the first detect sample is formed in the same cycle.
// Reset clears all tracker state; a restart action does the same in band.
// A stalled result holds the stage register, which stalls the input.
// ---------------------------------------------------------------------------
module hysteresis_peak_trough_detector #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            event_kind_o,
  output logic [hptd_pkg::INDEX_W-1:0]    event_index_o,
  output logic [hptd_pkg::ORDINAL_W-1:0]  event_ordinal_o
);

  import hptd_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int CW = SAMPLE_BITS + 2;
  localparam int PW = $clog2(MAX_SAMPLES + 1);
  localparam logic [PW-1:0] MaxPos = PW'(MAX_SAMPLES);

  // Stage register.
  logic                 s_valid_q;
  logic [1:0]           s_action_q;
  logic signed [SB-1:0] s_sample_q;

  // Tracker state.
  logic signed [SB-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic                  seen_q, seen_d;
  logic [SB-1:0]         hyst_q, hyst_d;
  dir_e                  dir_q, dir_d;
  logic signed [SB-1:0]  hv_q, hv_d, lv_q, lv_d;
  logic [INDEX_W-1:0]    hidx_q, hidx_d, lidx_q, lidx_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [ORDINAL_W-1:0]  peaks_q, peaks_d, troughs_q, troughs_d;

  // Result register.
  logic                  out_valid_q;
  logic                  kind_q;
  logic [INDEX_W-1:0]    index_q;
  logic [ORDINAL_W-1:0]  ord_q;

  // Threshold.
  logic [SB:0] div_dividend, div_quo;
  logic [SB:0] span;

  logic fire, out_free, in_accept;
  logic emit, emit_kind;
  logic [INDEX_W-1:0]   emit_index;
  logic [ORDINAL_W-1:0] emit_ord;

  logic                  first;
  logic [SB-1:0]         e;
  logic signed [SB-1:0]  cur_hv, cur_lv;
  logic [INDEX_W-1:0]    cur_hidx, cur_lidx, p_idx;
  logic signed [CW-1:0]  x_w, e_w, hv_w, lv_w;
  logic                  hv_le_x, hv_ge_xe, x_le_lv, x_ge_lve;

  // Handshake: the stage advances when the result register can take a result.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s_valid_q && out_free;
  assign in_stall_o = s_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_accept) begin
      s_valid_q <= 1'b1;
    end else if (fire) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s_action_q <= action_i;
      s_sample_q <= sample_i;
    end
  end

  // Twice the measured range, divided by five.
  assign span         = seen_q ? (SB + 1)'({hi_q[SB-1], hi_q} - {lo_q[SB-1], lo_q}) : '0;
  assign div_dividend = {span[SB-1:0], 1'b0};

  hptd_div5 #(
    .DW (SB + 1)
  ) u_div5 (
    .dividend_i (div_dividend),
    .quotient_o (div_quo)
  );

  // Working candidates: the first detect sample seeds both of them.
  assign first    = (pos_q == '0);
  assign e        = first ? div_quo[SB-1:0] : hyst_q;
  assign cur_hv   = first ? s_sample_q : hv_q;
  assign cur_lv   = first ? s_sample_q : lv_q;
  assign cur_hidx = first ? '0 : hidx_q;
  assign cur_lidx = first ? '0 : lidx_q;
  assign p_idx    = INDEX_W'(pos_q);

  // Comparisons at two bits over the sample width.
  assign x_w      = CW'(s_sample_q);
  assign e_w      = signed'({2'b00, e});
  assign hv_w     = CW'(cur_hv);
  assign lv_w     = CW'(cur_lv);
  assign hv_le_x  = (hv_w <= x_w);
  assign hv_ge_xe = (hv_w >= x_w + e_w);
  assign x_le_lv  = (x_w <= lv_w);
  assign x_ge_lve = (x_w >= lv_w + e_w);

  // Tracker update for the transaction in the stage register.
  always_comb begin
    lo_d       = lo_q;
    hi_d       = hi_q;
    seen_d     = seen_q;
    hyst_d     = hyst_q;
    dir_d      = dir_q;
    hv_d       = hv_q;
    lv_d       = lv_q;
    hidx_d     = hidx_q;
    lidx_d     = lidx_q;
    pos_d      = pos_q;
    peaks_d    = peaks_q;
    troughs_d  = troughs_q;
    emit       = 1'b0;
    emit_kind  = EVT_PEAK;
    emit_index = cur_hidx;
    emit_ord   = peaks_q;
    if (fire) begin
      case (s_action_q)
        ACT_RESTART: begin
          lo_d      = '0;
          hi_d      = '0;
          seen_d    = 1'b0;
          hyst_d    = '0;
          dir_d     = DIR_UNDECIDED;
          hv_d      = '0;
          lv_d      = '0;
          hidx_d    = '0;
          lidx_d    = '0;
          pos_d     = '0;
          peaks_d   = '0;
          troughs_d = '0;
        end
        ACT_MEASURE: begin
          seen_d = 1'b1;
          if (!seen_q || (s_sample_q < lo_q)) begin
            lo_d = s_sample_q;
          end
          if (!seen_q || (s_sample_q > hi_q)) begin
            hi_d = s_sample_q;
          end
        end
        ACT_DETECT: begin
          if (pos_q < MaxPos) begin
            hyst_d = e;
            hv_d   = cur_hv;
            lv_d   = cur_lv;
            hidx_d = cur_hidx;
            lidx_d = cur_lidx;
            pos_d  = pos_q + 1'b1;
            case (dir_q)
              DIR_UNDECIDED: begin
                if (hv_ge_xe) begin
                  dir_d = DIR_FALLING;
                end else if (x_ge_lve) begin
                  dir_d = DIR_RISING;
                end
                if (hv_le_x) begin
                  hv_d   = s_sample_q;
                  hidx_d = p_idx;
                end else if (x_le_lv) begin
                  lv_d   = s_sample_q;
                  lidx_d = p_idx;
                end
              end
              DIR_RISING: begin
                if (hv_le_x) begin
                  hv_d   = s_sample_q;
                  hidx_d = p_idx;
                end else if (hv_ge_xe) begin
                  emit       = 1'b1;
                  emit_kind  = EVT_PEAK;
                  emit_index = cur_hidx;
                  emit_ord   = peaks_q;
                  peaks_d    = peaks_q + 1'b1;
                  lv_d       = s_sample_q;
                  lidx_d     = p_idx;
                  dir_d      = DIR_FALLING;
                end
              end
              DIR_FALLING: begin
                if (x_le_lv) begin
                  lv_d   = s_sample_q;
                  lidx_d = p_idx;
                end else if (x_ge_lve) begin
                  emit       = 1'b1;
                  emit_kind  = EVT_TROUGH;
                  emit_index = cur_lidx;
                  emit_ord   = troughs_q;
                  troughs_d  = troughs_q + 1'b1;
                  hv_d       = s_sample_q;
                  hidx_d     = p_idx;
                  dir_d      = DIR_RISING;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q      <= '0;
      hi_q      <= '0;
      seen_q    <= 1'b0;
      hyst_q    <= '0;
      dir_q     <= DIR_UNDECIDED;
      hv_q      <= '0;
      lv_q      <= '0;
      hidx_q    <= '0;
      lidx_q    <= '0;
      pos_q     <= '0;
      peaks_q   <= '0;
      troughs_q <= '0;
    end else begin
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      seen_q    <= seen_d;
      hyst_q    <= hyst_d;
      dir_q     <= dir_d;
      hv_q      <= hv_d;
      lv_q      <= lv_d;
      hidx_q    <= hidx_d;
      lidx_q    <= lidx_d;
      pos_q     <= pos_d;
      peaks_q   <= peaks_d;
      troughs_q <= troughs_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      kind_q  <= emit_kind;
      index_q <= emit_index;
      ord_q   <= emit_ord;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign event_index_o   = index_q;
  assign event_ordinal_o = ord_q;

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=>
      (out_valid_q && $stable(kind_q) && $stable(index_q) && $stable(ord_q)))
    else $error("stalled result changed");

  // The detect position never passes the record limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("detect position beyond record limit");

  // The threshold is at most 0.4 of the range, so its top bit stays clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hyst_q[SB-1])
    else $error("hysteresis threshold out of range");

  // Each reported peak advances the peak count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit && (emit_kind == EVT_PEAK)) |=>
      (peaks_q == $past(peaks_q) + 1'b1) && (ord_q == $past(peaks_q)))
    else $error("peak count did not advance with a reported peak");

endmodule : hysteresis_peak_trough_detector
`default_nettype wire
